>>> hw/rtl/multi_waveform_oscillator_core_defines.svh
// ----------------------------------------------------------------------------
// Oscillator core assertion macros
// Shared concurrent assertion wrappers for the oscillator RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_DEFINES_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MWO_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define MWO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mwo_pkg.sv
// ----------------------------------------------------------------------------
// Oscillator package
// Widths, register indexes, waveform codes, pipeline types and the sine ROM.
// ----------------------------------------------------------------------------
package mwo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;

    localparam int AMP_BITS        = 15;
    localparam int SAMPLE_BITS     = 16;
    localparam int STEP_BITS       = 32;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_INDEX_BITS  = 2;

    // Magnitude of a phase-derived multiplicand can reach one full period.
    localparam int MAG_BITS        = PHASE_BITS + 1;
    localparam int PROD_BITS       = AMP_BITS + MAG_BITS;
    // Signed headroom for 3 * full - 4 * phase.
    localparam int DIFF_BITS       = PHASE_BITS + 3;
    localparam int STEP_EXT_BITS   = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;

    localparam int SINE_FULL_SCALE = 32767;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SELECT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE   = 2'd2;

    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_SAW      = 2'd2;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

    localparam logic [AMP_BITS-1:0] AMP_RESET = 15'd16383;

    typedef logic signed [SAMPLE_BITS-1:0] sine_rom_t [TABLE_SIZE];

    // Phase and table value of one tick leaving the ROM stage.
    typedef struct packed {
        logic                          valid;
        logic [PHASE_BITS-1:0]         phase;
        logic signed [SAMPLE_BITS-1:0] sine;
    } stage1_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam int          TAYLOR_TERMS = 12;

    // Denominators (2n)(2n+1) of the successive Taylor terms.
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // Rounded 32767 * sin(pi/2 * q / quarter) in Q30 fixed point.
    function automatic logic [15:0] quarter_sine(input int unsigned q);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (64'(q) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        term = x;
        sum  = x;
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / TAYLOR_DIV[4'(n - 1)];
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[15:0];
    endfunction

    // Full-period table built from the first quarter wave by mirroring.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        int unsigned r;
        int unsigned q;
        logic [15:0] v;
        for (int unsigned k = 0; k < TABLE_SIZE; k++)
        begin
            r = (k < TABLE_SIZE / 2) ? k : k - TABLE_SIZE / 2;
            q = (r <= TABLE_SIZE / 4) ? r : TABLE_SIZE / 2 - r;
            v = quarter_sine(q);
            rom[k[SINE_TABLE_BITS-1:0]] = (k < TABLE_SIZE / 2) ? $signed(v) : -$signed(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> hw/rtl/mwo_channels.sv
// ----------------------------------------------------------------------------
// Oscillator channels
// Valid/ready interfaces for sample ticks and output samples.
// ----------------------------------------------------------------------------
interface mwo_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface mwo_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

>>> hw/rtl/mwo_shaper.sv
// ----------------------------------------------------------------------------
// Oscillator wave shaper
// Turns a phase and its sine table value into one scaled output sample.
// ----------------------------------------------------------------------------
`include "multi_waveform_oscillator_core_defines.svh"

module mwo_shaper (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [1:0]                     wave_select,
    input  logic [mwo_pkg::AMP_BITS-1:0]   amplitude,
    input  mwo_pkg::stage1_t               s1,
    output logic                           s1_ready,
    mwo_sample_if.source                   result
);
    import mwo_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_EXCLUDED = 16'h8000;
    localparam logic [DIFF_BITS-1:0]   FULL_DIFF = DIFF_BITS'(1) << PHASE_BITS;

    logic                  v2_reg;
    logic [PROD_BITS-1:0]  prod2_reg;
    logic [PROD_BITS-1:0]  prod2_next;
    logic                  neg2_reg;
    logic                  neg2_next;
    logic                  sine2_reg;

    logic                  v3_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;

    logic                  s2_ready;
    logic                  s3_ready;

    logic                  upper;
    logic [DIFF_BITS-1:0]  ph_ext;
    logic [DIFF_BITS-1:0]  diff;
    logic [SAMPLE_BITS-1:0] sine_abs;
    logic [MAG_BITS-1:0]   mag;

    logic [AMP_BITS-1:0]   q0;
    logic [AMP_BITS:0]     rem;
    logic [AMP_BITS-1:0]   sine_q;
    logic [AMP_BITS-1:0]   mag3;

    assign s3_ready = !v3_reg || result.ready;
    assign s2_ready = !v2_reg || s3_ready;
    assign s1_ready = s2_ready;

    // Signed multiplicand as sign and magnitude, so every product truncates toward zero.
    always_comb
    begin
        upper    = s1.phase[PHASE_BITS-1];
        ph_ext   = DIFF_BITS'(s1.phase);
        sine_abs = s1.sine[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s1.sine) : SAMPLE_BITS'(s1.sine);
        diff     = '0;
        case (wave_select)
            WAVE_SAW:
                diff = (ph_ext << 1) - FULL_DIFF;
            WAVE_TRIANGLE:
                diff = upper ? (3 * FULL_DIFF) - (ph_ext << 2) : (ph_ext << 2) - FULL_DIFF;
            default:
                diff = '0;
        endcase
        case (wave_select)
            WAVE_SINE:
            begin
                neg2_next = s1.sine[SAMPLE_BITS-1];
                mag       = MAG_BITS'(sine_abs[AMP_BITS-1:0]);
            end
            WAVE_SQUARE:
            begin
                neg2_next = upper;
                mag       = FULL_DIFF[MAG_BITS-1:0];
            end
            default:
            begin
                neg2_next = diff[DIFF_BITS-1];
                mag       = diff[DIFF_BITS-1] ? MAG_BITS'(-diff) : diff[MAG_BITS-1:0];
            end
        endcase
        prod2_next = PROD_BITS'(amplitude) * PROD_BITS'(mag);
    end

    // Division by 32767: x = q0 * 32767 + (q0 + low bits), and that remainder
    // stays below twice the divisor, so one compare finishes the quotient.
    always_comb
    begin
        q0     = prod2_reg[2*AMP_BITS-1:AMP_BITS];
        rem    = {1'b0, prod2_reg[AMP_BITS-1:0]} + {1'b0, q0};
        sine_q = (rem >= (AMP_BITS+1)'(SINE_FULL_SCALE)) ? q0 + 1'b1 : q0;
        mag3   = sine2_reg ? sine_q : prod2_reg[PHASE_BITS +: AMP_BITS];
        sample_next = neg2_reg ? -{1'b0, mag3} : {1'b0, mag3};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                v2_reg <= s1.valid;
            if (s3_ready)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1.valid)
        begin
            prod2_reg <= prod2_next;
            neg2_reg  <= neg2_next;
            sine2_reg <= (wave_select == WAVE_SINE);
        end
        if (s3_ready && v2_reg)
            sample_reg <= sample_next;
    end

    assign result.valid  = v3_reg;
    assign result.sample = sample_reg;

    `MWO_ASSERT_NEXT(a_s2_load, clk, rst_n, s1.valid && s2_ready, v2_reg,
        "product stage did not load")
    `MWO_ASSERT_ALWAYS(a_ready_when_empty, clk, rst_n, !v3_reg |-> s1_ready,
        "pipeline stalled with an empty output register")
    `MWO_ASSERT_ALWAYS(a_sample_range, clk, rst_n,
        v3_reg |-> (sample_reg != SAMPLE_EXCLUDED), "sample outside symmetric range")

endmodule

>>> hw/rtl/multi_waveform_oscillator_core.sv
// ----------------------------------------------------------------------------
// Multi-waveform oscillator core
// Phase accumulator oscillator with sine, square, sawtooth and triangle output.
// ----------------------------------------------------------------------------
// Each accepted tick yields one signed 16-bit sample, and a new tick is
// taken every clock while the output is not stalled. The only loop is the
// 32-bit phase adder; the sine comes from a registered 1024-entry ROM,
// followed by one 15 by 33 bit multiply stage and an output stage that
// scales the product. A restart tick zeroes the phase before its sample is
// formed. The user must write registers through the cfg port only while no
// tick is in flight; the block does not enforce it.
`include "multi_waveform_oscillator_core_defines.svh"

module multi_waveform_oscillator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mwo_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mwo_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    mwo_tick_if.sink                             tick,
    mwo_sample_if.source                         result
);
    import mwo_pkg::*;

    logic [1:0]            wave_select_reg;
    logic [STEP_BITS-1:0]  phase_step_reg;
    logic [AMP_BITS-1:0]   amplitude_reg;

    logic [PHASE_BITS-1:0] phase_accum_reg;
    logic [PHASE_BITS-1:0] phase_accum_next;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [STEP_EXT_BITS-1:0] step_wide;
    logic [PHASE_BITS-1:0] step_eff;

    logic                  s1_valid_reg;
    logic [PHASE_BITS-1:0] s1_phase_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sine_reg;
    stage1_t               s1;
    logic                  s2_ready;
    logic                  accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_select_reg <= WAVE_SINE;
            phase_step_reg  <= '0;
            amplitude_reg   <= AMP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WAVE_SELECT: wave_select_reg <= cfg_data[1:0];
                REG_PHASE_STEP:  phase_step_reg  <= cfg_data[STEP_BITS-1:0];
                REG_AMPLITUDE:   amplitude_reg   <= cfg_data[AMP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign tick.ready = !s1_valid_reg || s2_ready;
    assign accept     = tick.valid && tick.ready;

    always_comb
    begin
        step_wide        = STEP_EXT_BITS'(phase_step_reg);
        step_eff         = step_wide[PHASE_BITS-1:0];
        phase_cur        = tick.restart ? '0 : phase_accum_reg;
        phase_accum_next = phase_cur + step_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_accum_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
                phase_accum_reg <= phase_accum_next;
            if (tick.ready)
                s1_valid_reg <= tick.valid;
        end
    end

    // Sine ROM read, registered together with the phase of the same tick.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_phase_reg <= phase_cur;
            s1_sine_reg  <= SINE_ROM[phase_cur[PHASE_BITS-1 -: SINE_TABLE_BITS]];
        end
    end

    assign s1.valid = s1_valid_reg;
    assign s1.phase = s1_phase_reg;
    assign s1.sine  = s1_sine_reg;

    mwo_shaper u_shaper (
        .clk         (clk),
        .rst_n       (rst_n),
        .wave_select (wave_select_reg),
        .amplitude   (amplitude_reg),
        .s1          (s1),
        .s1_ready    (s2_ready),
        .result      (result)
    );

    `MWO_ASSERT_NEXT(a_restart_zero, clk, rst_n, accept && tick.restart,
        s1_phase_reg == '0, "restart tick did not start from zero phase")
    `MWO_ASSERT_NEXT(a_accum_step, clk, rst_n, accept,
        phase_accum_reg == PHASE_BITS'(s1_phase_reg + step_eff),
        "phase accumulator did not advance by the step")
    `MWO_ASSERT_NEXT(a_accum_hold, clk, rst_n, !accept, $stable(phase_accum_reg),
        "phase accumulator moved without a transaction")

endmodule
